[rtl/rmpa_pkg.sv]
package rmpa_pkg;

  // fixed widths of the result fields
  localparam int TaskIdW = 5;
  localparam int PrioW   = 6;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic load_key;
    logic clear;
    logic step;
  } rank_ctrl_t;

endpackage

[rtl/rmpa_store.sv]
module rmpa_store #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/rmpa_rank.sv]
module rmpa_rank #(
  parameter int PeriodW = 16,
  parameter int IdxW    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmpa_pkg::rank_ctrl_t ctrl_i,
  input  logic [PeriodW-1:0]   rd_data_i,
  input  logic [IdxW-1:0]      j_i,
  input  logic [IdxW-1:0]      idx_i,
  output logic [IdxW-1:0]      rank_o
);

  logic [PeriodW-1:0] key_q;
  logic [IdxW-1:0]    rank_q;
  logic               hit;

  // shorter period, or equal period that arrived earlier
  assign hit = (rd_data_i < key_q) || ((rd_data_i == key_q) && (j_i < idx_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_key) begin
      key_q <= rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else if (ctrl_i.clear) begin
      rank_q <= '0;
    end else if (ctrl_i.step && hit) begin
      rank_q <= rank_q + IdxW'(1);
    end
  end

  assign rank_o = rank_q;

endmodule

[rtl/rate_monotonic_priority_assign.sv]
// channel   direction  handshake           payload
// task      in         start_i / busy_o    period_i, last_task_i
// result    out        valid_o (strobe)    task_id_o, priority_res_o, last_result_o, overflow_o
//
// a task loads whenever start_i is high and busy_o low; busy_o stays low between tasks of a set
// after the last task each result is made in these steps: key read,
// key capture, one period compare per stored task on the single compare unit
// and read port of the period store, then the result
// busy_o stays high from the last task of a set through its final result
// reset clears the task count, the drop flag and the sequencer; the store needs none
// results cannot be held off: each is shown for exactly one cycle
module rate_monotonic_priority_assign #(
  parameter int MAX_TASKS   = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [PERIOD_BITS-1:0]       period_i,
  input  logic                         last_task_i,
  output logic                         valid_o,
  output logic [rmpa_pkg::TaskIdW-1:0] task_id_o,
  output logic [rmpa_pkg::PrioW-1:0]   priority_res_o,
  output logic                         last_result_o,
  output logic                         overflow_o
);

  localparam int IdxW = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_KEY   = 5'b00010,
    S_CAPT  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 drop_q, drop_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      j_q, j_d;
  logic [IdxW-1:0]      last_j;
  logic                 accept;
  logic                 wr_en;
  logic [IdxW-1:0]      rd_addr;
  logic [PERIOD_BITS-1:0] rd_data;
  logic [IdxW-1:0]      rank;
  rmpa_pkg::rank_ctrl_t ctrl;

  assign busy_o = (state_q != S_LOAD);
  assign accept = start_i && !busy_o;
  assign last_j = IdxW'(count_q - CntW'(1));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drop_d  = drop_q;
    idx_d   = idx_q;
    j_d     = j_q;
    wr_en   = 1'b0;
    rd_addr = '0;
    ctrl    = '0;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (count_q < CntW'(MAX_TASKS)) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_task_i) begin
            idx_d   = IdxW'(count_d - CntW'(1));
            state_d = S_KEY;
          end
        end
      end
      S_KEY: begin
        rd_addr = idx_q;
        state_d = S_CAPT;
      end
      S_CAPT: begin
        ctrl.load_key = 1'b1;
        ctrl.clear    = 1'b1;
        rd_addr       = '0;
        j_d           = '0;
        state_d       = S_SWEEP;
      end
      S_SWEEP: begin
        ctrl.step = 1'b1;
        if (j_q == last_j) begin
          state_d = S_EMIT;
        end else begin
          rd_addr = j_q + IdxW'(1);
          j_d     = j_q + IdxW'(1);
        end
      end
      S_EMIT: begin
        if (idx_q == '0) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = S_LOAD;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = S_KEY;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      idx_q   <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
    end
  end

  rmpa_store #(
    .Depth(MAX_TASKS),
    .Width(PERIOD_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[IdxW-1:0]),
    .wr_data_i(period_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  rmpa_rank #(
    .PeriodW(PERIOD_BITS),
    .IdxW   (IdxW)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .rd_data_i(rd_data),
    .j_i      (j_q),
    .idx_i    (idx_q),
    .rank_o   (rank)
  );

  // result fields, widened then cut to the field widths
  logic [CntW-1:0]                       id_num;
  logic [CntW+rmpa_pkg::TaskIdW-1:0]     id_ext;
  logic [CntW-1:0]                       rank1;
  logic [CntW+1:0]                       prio_num;
  logic [CntW+rmpa_pkg::PrioW+1:0]       prio_ext;

  assign id_num   = CntW'(idx_q) + CntW'(1);
  assign id_ext   = {{rmpa_pkg::TaskIdW{1'b0}}, id_num};
  assign rank1    = CntW'(rank) + CntW'(1);
  assign prio_num = {2'b00, rank1} + {1'b0, rank1, 1'b0};
  assign prio_ext = {{rmpa_pkg::PrioW{1'b0}}, prio_num};

  assign valid_o        = (state_q == S_EMIT);
  assign task_id_o      = id_ext[rmpa_pkg::TaskIdW-1:0];
  assign priority_res_o = prio_ext[rmpa_pkg::PrioW-1:0];
  assign last_result_o  = (idx_q == '0);
  assign overflow_o     = drop_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_last_task_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_task_i |=> busy_o)
    else $error("not busy after last task");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("results in consecutive cycles");

  a_final_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_result_o |=> !busy_o && (count_q == '0) && !drop_q)
    else $error("block not cleared after final result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TASKS))
    else $error("task count beyond capacity");

endmodule

[verif/rmpa_result_checker.sv]
`timescale 1ns / 1ps

module rmpa_result_checker #(
  parameter int MAX_TASKS   = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [PERIOD_BITS-1:0]       period_i,
  input  logic                         last_task_i,
  input  logic                         valid_i,
  input  logic [rmpa_pkg::TaskIdW-1:0] task_id_i,
  input  logic [rmpa_pkg::PrioW-1:0]   priority_res_i,
  input  logic                         last_result_i,
  input  logic                         overflow_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  localparam int PrioStep = 3;

  typedef struct packed {
    logic [rmpa_pkg::TaskIdW-1:0] task_id;
    logic [rmpa_pkg::PrioW-1:0]   prio;
    logic                         last;
    logic                         ovf;
  } prio_result_t;

  prio_result_t           prio_expect_q[$];
  logic [PERIOD_BITS-1:0] period_mem [MAX_TASKS];
  int                     tasks_held;
  logic                   drop_seen;

  always @(posedge clk_i or negedge rst_ni) begin : track_and_compare
    prio_result_t want;
    prio_result_t got;
    int           rank;
    if (!rst_ni) begin
      tasks_held       = 0;
      drop_seen        = 1'b0;
      mismatch_count_o = 0;
      pending_o        = 0;
      prio_expect_q.delete();
    end else begin
      if (start_i && !busy_i) begin
        if (tasks_held < MAX_TASKS) begin
          period_mem[tasks_held] = period_i;
          tasks_held++;
        end else begin
          drop_seen = 1'b1;
        end
        if (last_task_i) begin
          // results leave in descending task number
          for (int k = tasks_held - 1; k >= 0; k--) begin
            rank = 0;
            for (int j = 0; j < tasks_held; j++) begin
              // ties go to the earlier arrival
              if (period_mem[j] < period_mem[k] || (period_mem[j] == period_mem[k] && j < k))
                rank++;
            end
            want.task_id = rmpa_pkg::TaskIdW'(k + 1);
            want.prio    = rmpa_pkg::PrioW'(PrioStep * (rank + 1));
            want.last    = (k == 0);
            want.ovf     = drop_seen;
            prio_expect_q.push_back(want);
          end
          tasks_held = 0;
          drop_seen  = 1'b0;
        end
      end
      if (valid_i) begin
        got = '{task_id_i, priority_res_i, last_result_i, overflow_i};
        if (prio_expect_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("unexpected result: id %0d prio %0d last %0b ovf %0b",
                     got.task_id, got.prio, got.last, got.ovf);
          mismatch_count_o++;
        end else begin
          want = prio_expect_q.pop_front();
          if (got.task_id !== want.task_id || got.prio !== want.prio ||
              got.last !== want.last || got.ovf !== want.ovf) begin
            if (mismatch_count_o < 10) begin
              $display("result mismatch: expected id %0d prio %0d last %0b ovf %0b",
                       want.task_id, want.prio, want.last, want.ovf);
              $display("                 got      id %0d prio %0d last %0b ovf %0b",
                       got.task_id, got.prio, got.last, got.ovf);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_o = prio_expect_q.size();
    end
  end

endmodule

[verif/rate_monotonic_priority_assign_test.sv]
`timescale 1ns / 1ps

module rate_monotonic_priority_assign_test;

  localparam int MAX_TASKS   = 16;
  localparam int PERIOD_BITS = 16;
  localparam int ItemTarget  = 410;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 4 * (MAX_TASKS + 3);

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start_i     = 1'b0;
  logic [PERIOD_BITS-1:0]       period_i    = '0;
  logic                         last_task_i = 1'b0;
  logic                         busy_o;
  logic                         valid_o;
  logic [rmpa_pkg::TaskIdW-1:0] task_id_o;
  logic [rmpa_pkg::PrioW-1:0]   priority_res_o;
  logic                         last_result_o;
  logic                         overflow_o;

  int mismatch_count;
  int results_pending;
  int stall_cycles;
  int items_sent;
  bit idle_en;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rate_monotonic_priority_assign #(
    .MAX_TASKS  (MAX_TASKS),
    .PERIOD_BITS(PERIOD_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .period_i      (period_i),
    .last_task_i   (last_task_i),
    .valid_o       (valid_o),
    .task_id_o     (task_id_o),
    .priority_res_o(priority_res_o),
    .last_result_o (last_result_o),
    .overflow_o    (overflow_o)
  );

  rmpa_result_checker #(
    .MAX_TASKS  (MAX_TASKS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .period_i        (period_i),
    .last_task_i     (last_task_i),
    .valid_i         (valid_o),
    .task_id_i       (task_id_o),
    .priority_res_i  (priority_res_o),
    .last_result_i   (last_result_o),
    .overflow_i      (overflow_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (results_pending)
  );

  // cycles with neither an item taken nor a result shown
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [PERIOD_BITS-1:0] pick_period(int mode);
    case (mode)
      // small pool of values, many ties and both extremes
      1: return PERIOD_BITS'($urandom_range(0, 3) * 21845);
      // close neighbours
      2: return PERIOD_BITS'($urandom_range(1000, 1003));
      default: return PERIOD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_task(input logic [PERIOD_BITS-1:0] period, input logic is_last);
    if (idle_en) begin
      while ($urandom_range(0, 99) < 36) begin
        // payload noise while start is low
        start_i     <= 1'b0;
        period_i    <= PERIOD_BITS'($urandom);
        last_task_i <= 1'($urandom);
        @(posedge clk_i);
      end
    end
    start_i     <= 1'b1;
    period_i    <= period;
    last_task_i <= is_last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin : stimulus
    bit timed_out;
    int n;
    int mode;
    timed_out  = 1'b0;
    idle_en    = 1'b1;
    items_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        // single task at the shortest period
        send_task('0, 1'b1);
        // equal periods throughout
        repeat (2) send_task(PERIOD_BITS'(16'h8000), 1'b0);
        send_task(PERIOD_BITS'(16'h8000), 1'b1);
        // extremes and a tie
        send_task('1, 1'b0);
        send_task('0, 1'b0);
        send_task(PERIOD_BITS'(16'h8000), 1'b0);
        send_task(PERIOD_BITS'(16'h8000), 1'b1);
        // full set, last task dropped but still triggers ranking
        for (int i = 0; i <= MAX_TASKS; i++)
          send_task(PERIOD_BITS'((MAX_TASKS - i) * 2000), i == MAX_TASKS);

        while (items_sent < ItemTarget) begin
          idle_en = !(items_sent >= 150 && items_sent < 260);
          n = ($urandom_range(0, 99) < 12) ? $urandom_range(MAX_TASKS + 1, MAX_TASKS + 4)
                                           : $urandom_range(1, MAX_TASKS);
          mode = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 2);
          for (int i = 0; i < n; i++)
            send_task(pick_period(mode), i == n - 1);
        end
        start_i <= 1'b0;
        @(posedge clk_i);
        wait (results_pending == 0);
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin
        wait (stall_cycles >= StallLimit);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out) begin
      $display("Mismatches found");
    end else if (mismatch_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rmpa_pkg.sv
rtl/rmpa_store.sv
rtl/rmpa_rank.sv
rtl/rate_monotonic_priority_assign.sv
verif/rmpa_result_checker.sv
verif/rate_monotonic_priority_assign_test.sv
